### rtl/rsbi_pkg.sv
// rsbi_pkg: shared sizes, codes and helpers for the row strip box index
// used by rsbi_box_mem, rsbi_strip_mem and row_strip_box_index_top
`default_nettype none
package rsbi_pkg;

   localparam int MAX_BOXES   = 4096;
   localparam int MAX_STRIPS  = 1024;
   localparam int STRIP_SHIFT = 7;

   localparam int BOX_AW   = $clog2(MAX_BOXES);
   localparam int BOX_CW   = BOX_AW + 1;
   localparam int STRIP_AW = $clog2(MAX_STRIPS);
   localparam int STRIP_CW = STRIP_AW + 1;
   localparam int OFF_W    = 19;

   localparam logic [BOX_CW-1:0] EMPTY_MARK = BOX_CW'(MAX_BOXES);

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_BOXES  = 3'd1,
      ST_NOT_BUILT = 3'd2,
      ST_FULL      = 3'd3,
      ST_TOO_MANY  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MM_RD,
      S_MM_ACC,
      S_CALC,
      S_CLR,
      S_FILL_RD,
      S_FILL_SE,
      S_STRIP_RD,
      S_STRIP_WR,
      S_Q_RD,
      S_Q_ACC,
      S_FIN
   } fsm_type;

   typedef struct packed {
      logic signed [15:0] top;
      logic [14:0]        height;
   } box_type;

   typedef struct packed {
      logic [BOX_CW-1:0] first;
      logic [BOX_AW-1:0] last;
   } strip_type;

   // strip number of a row offset from the origin, negative offsets give 0
   function automatic logic [OFF_W-1:0] strip_of(input logic signed [OFF_W-1:0] off);
      logic signed [OFF_W-1:0] sh;
      sh = off >>> STRIP_SHIFT;
      return off[OFF_W-1] ? '0 : OFF_W'(sh);
   endfunction

endpackage
`default_nettype wire

### rtl/rsbi_box_mem.sv
// rsbi_box_mem: box store, one write and one registered read port
// depends on rsbi_pkg
`default_nettype none
module rsbi_box_mem (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [rsbi_pkg::BOX_AW-1:0] wr_addr,
   input  wire rsbi_pkg::box_type      wr_data,
   input  wire logic [rsbi_pkg::BOX_AW-1:0] rd_addr,
   output rsbi_pkg::box_type           rd_data
);
   import rsbi_pkg::*;

   box_type mem [MAX_BOXES];
   box_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### rtl/rsbi_strip_mem.sv
// rsbi_strip_mem: strip table holding first and last box index per strip
// depends on rsbi_pkg
`default_nettype none
module rsbi_strip_mem (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [rsbi_pkg::STRIP_AW-1:0] wr_addr,
   input  wire rsbi_pkg::strip_type      wr_data,
   input  wire logic [rsbi_pkg::STRIP_AW-1:0] rd_addr,
   output rsbi_pkg::strip_type           rd_data
);
   import rsbi_pkg::*;

   strip_type mem [MAX_STRIPS];
   strip_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### rtl/row_strip_box_index_top.sv
// row_strip_box_index_top: load, build and query of a strip index over boxes
// load, clear and failed requests go through S_FIN to the result register; a query
// reads each spanned strip in turn; a build walks the boxes for the min/max, clears
// all 1024 table entries, then files each box into every strip it covers.
// one request at a time; box store and strip table each have one write and one read port.
// synchronous reset clears counts and the built flag; memories are not cleared.
// depends on rsbi_pkg, rsbi_box_mem, rsbi_strip_mem
`default_nettype none
module row_strip_box_index_top (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_opcode,
   input  wire logic signed [15:0]     req_box_top,
   input  wire logic [14:0]            req_box_height,
   input  wire logic signed [15:0]     req_span_top,
   input  wire logic signed [15:0]     req_span_bottom,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [2:0]                  rsp_status,
   output logic                        rsp_found,
   output logic [11:0]                 rsp_first_index,
   output logic [12:0]                 rsp_after_index,
   output logic [10:0]                 rsp_strip_total
);
   import rsbi_pkg::*;

   // control registers
   fsm_type                    state_ff, state_in;
   logic [BOX_CW-1:0]          box_count_ff, box_count_in;
   logic signed [15:0]         origin_ff, origin_in;
   logic [STRIP_CW-1:0]        strip_count_ff, strip_count_in;
   logic [BOX_AW-1:0]          k_ff, k_in;
   logic [STRIP_AW-1:0]        sidx_ff, sidx_in;
   logic [STRIP_AW-1:0]        send_ff, send_in;
   logic signed [15:0]         ymin_ff, ymin_in;
   logic signed [OFF_W-1:0]    ymax_ff, ymax_in;
   logic                       found_ff, found_in;
   logic [BOX_AW-1:0]          lo_ff, lo_in;
   logic [BOX_AW-1:0]          hi_ff, hi_in;
   status_type                 status_ff, status_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [2:0]                 rsp_status_ff, rsp_status_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [11:0]                rsp_first_ff, rsp_first_in;
   logic [12:0]                rsp_after_ff, rsp_after_in;
   logic [10:0]                rsp_total_ff, rsp_total_in;

   // memory ports
   logic                       box_wr_en;
   box_type                    box_wr_data, box_rd_data;
   logic [BOX_AW-1:0]          box_rd_addr;
   logic                       strip_wr_en;
   logic [STRIP_AW-1:0]        strip_wr_addr, strip_rd_addr;
   strip_type                  strip_wr_data, strip_rd_data;

   // datapath helpers
   logic signed [OFF_W-1:0]    top_x, bot_x, range_x, cnt_x, ymin_x;
   logic [OFF_W-1:0]           s_x, e_x, last_x, qs_x, qe_x;
   logic                       req_xfer, last_box;

   rsbi_box_mem u_box_mem (
      .clock   (clock),
      .wr_en   (box_wr_en),
      .wr_addr (box_count_ff[BOX_AW-1:0]),
      .wr_data (box_wr_data),
      .rd_addr (box_rd_addr),
      .rd_data (box_rd_data)
   );

   rsbi_strip_mem u_strip_mem (
      .clock   (clock),
      .wr_en   (strip_wr_en),
      .wr_addr (strip_wr_addr),
      .wr_data (strip_wr_data),
      .rd_addr (strip_rd_addr),
      .rd_data (strip_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign box_wr_data.top    = req_box_top;
   assign box_wr_data.height = req_box_height;

   // box geometry from the store read port
   assign top_x   = OFF_W'(box_rd_data.top);
   assign bot_x   = top_x + $signed({4'b0, box_rd_data.height}) - OFF_W'(1);
   assign ymin_x  = OFF_W'(ymin_ff);
   assign range_x = ymax_ff - ymin_x;
   assign cnt_x   = ((range_x + OFF_W'((1 << STRIP_SHIFT) - 1)) >>> STRIP_SHIFT)
                    + OFF_W'(1);
   assign last_x  = OFF_W'(strip_count_ff) - OFF_W'(1);
   assign s_x     = strip_of(top_x - ymin_x);
   assign e_x     = strip_of(bot_x - ymin_x);
   // query strip range relative to the built origin
   assign qs_x    = strip_of(OFF_W'(req_span_top) - OFF_W'(origin_ff));
   assign qe_x    = strip_of(OFF_W'(req_span_bottom) - OFF_W'(origin_ff));
   assign last_box = ({1'b0, k_ff} + BOX_CW'(1)) == box_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         box_count_ff   <= '0;
         origin_ff      <= '0;
         strip_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         box_count_ff   <= box_count_in;
         origin_ff      <= origin_in;
         strip_count_ff <= strip_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      sidx_ff       <= sidx_in;
      send_ff       <= send_in;
      ymin_ff       <= ymin_in;
      ymax_ff       <= ymax_in;
      found_ff      <= found_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_after_ff  <= rsp_after_in;
      rsp_total_ff  <= rsp_total_in;
   end

   always_comb begin
      logic [OFF_W-1:0] a;
      logic [OFF_W-1:0] b;
      logic [OFF_W-1:0] e;
      state_in       = state_ff;
      box_count_in   = box_count_ff;
      origin_in      = origin_ff;
      strip_count_in = strip_count_ff;
      k_in           = k_ff;
      sidx_in        = sidx_ff;
      send_in        = send_ff;
      ymin_in        = ymin_ff;
      ymax_in        = ymax_ff;
      found_in       = found_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_first_in   = rsp_first_ff;
      rsp_after_in   = rsp_after_ff;
      rsp_total_in   = rsp_total_ff;
      box_wr_en      = 1'b0;
      box_rd_addr    = k_ff;
      strip_wr_en    = 1'b0;
      strip_wr_addr  = sidx_ff;
      strip_wr_data  = '{first: EMPTY_MARK, last: '0};
      strip_rd_addr  = sidx_ff;
      a = '0;
      b = '0;
      e = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               status_in = ST_OK;
               found_in  = 1'b0;
               k_in      = '0;
               state_in  = S_FIN;
               case (opcode_type'(req_opcode))
                  OP_LOAD: begin
                     if (box_count_ff >= BOX_CW'(MAX_BOXES)) begin
                        status_in = ST_FULL;
                     end else begin
                        box_wr_en      = 1'b1;
                        box_count_in   = box_count_ff + BOX_CW'(1);
                        strip_count_in = '0;
                     end
                  end
                  OP_BUILD: begin
                     strip_count_in = '0;
                     if (box_count_ff == '0) begin
                        status_in = ST_NO_BOXES;
                     end else begin
                        state_in = S_MM_RD;
                     end
                  end
                  OP_QUERY: begin
                     if (strip_count_ff == '0) begin
                        status_in = ST_NOT_BUILT;
                     end else begin
                        // clamp to the last strip, then order the pair
                        a = (qs_x > last_x) ? last_x : qs_x;
                        b = (qe_x > last_x) ? last_x : qe_x;
                        if (a > b) begin
                           sidx_in = b[STRIP_AW-1:0];
                           send_in = a[STRIP_AW-1:0];
                        end else begin
                           sidx_in = a[STRIP_AW-1:0];
                           send_in = b[STRIP_AW-1:0];
                        end
                        state_in = S_Q_RD;
                     end
                  end
                  default: begin
                     box_count_in   = '0;
                     origin_in      = '0;
                     strip_count_in = '0;
                  end
               endcase
            end
         end
         // pass one: min top and max bottom over the store
         S_MM_RD: begin
            state_in = S_MM_ACC;
         end
         S_MM_ACC: begin
            if (k_ff == '0 || top_x < ymin_x) begin
               ymin_in = box_rd_data.top;
            end
            if (k_ff == '0 || bot_x > ymax_ff) begin
               ymax_in = bot_x;
            end
            k_in     = k_ff + BOX_AW'(1);
            state_in = last_box ? S_CALC : S_MM_RD;
         end
         S_CALC: begin
            origin_in = ymin_ff;
            if (cnt_x > OFF_W'(MAX_STRIPS)) begin
               status_in = ST_TOO_MANY;
               state_in  = S_FIN;
            end else begin
               strip_count_in = cnt_x[STRIP_CW-1:0];
               sidx_in        = '0;
               state_in       = S_CLR;
            end
         end
         // wipe the strip table, one entry a cycle
         S_CLR: begin
            strip_wr_en = 1'b1;
            sidx_in     = sidx_ff + STRIP_AW'(1);
            if (sidx_ff == STRIP_AW'(MAX_STRIPS - 1)) begin
               k_in     = '0;
               state_in = S_FILL_RD;
            end
         end
         // pass two: file each box into the strips it covers
         S_FILL_RD: begin
            state_in = S_FILL_SE;
         end
         S_FILL_SE: begin
            e = (e_x > last_x) ? last_x : e_x;
            sidx_in = s_x[STRIP_AW-1:0];
            send_in = e[STRIP_AW-1:0];
            if (s_x <= e) begin
               state_in = S_STRIP_RD;
            end else begin
               k_in     = k_ff + BOX_AW'(1);
               state_in = last_box ? S_FIN : S_FILL_RD;
            end
         end
         S_STRIP_RD: begin
            state_in = S_STRIP_WR;
         end
         S_STRIP_WR: begin
            // boxes arrive in ascending order, so first is set once and last follows k
            strip_wr_en         = 1'b1;
            strip_wr_data.first = (strip_rd_data.first == EMPTY_MARK) ?
                                  {1'b0, k_ff} : strip_rd_data.first;
            strip_wr_data.last  = k_ff;
            if (sidx_ff == send_ff) begin
               k_in     = k_ff + BOX_AW'(1);
               state_in = last_box ? S_FIN : S_FILL_RD;
            end else begin
               sidx_in  = sidx_ff + STRIP_AW'(1);
               state_in = S_STRIP_RD;
            end
         end
         // query: merge index ranges of the spanned strips
         S_Q_RD: begin
            state_in = S_Q_ACC;
         end
         S_Q_ACC: begin
            if (strip_rd_data.first != EMPTY_MARK) begin
               found_in = 1'b1;
               if (!found_ff || strip_rd_data.first[BOX_AW-1:0] < lo_ff) begin
                  lo_in = strip_rd_data.first[BOX_AW-1:0];
               end
               if (!found_ff || strip_rd_data.last > hi_ff) begin
                  hi_in = strip_rd_data.last;
               end
            end
            if (sidx_ff == send_ff) begin
               state_in = S_FIN;
            end else begin
               sidx_in  = sidx_ff + STRIP_AW'(1);
               state_in = S_Q_RD;
            end
         end
         // hand the result over once the output register is free
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_first_in  = found_ff ? 12'(lo_ff) : '0;
               rsp_after_in  = found_ff ? (13'(hi_ff) + 13'd1) : '0;
               rsp_total_in  = 11'(strip_count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_first_index = rsp_first_ff;
   assign rsp_after_index = rsp_after_ff;
   assign rsp_strip_total = rsp_total_ff;
endmodule
`default_nettype wire
